[design/nsc_pkg.sv]
// shared types, character codes and helpers for the nmea sentence checksum checker
// no dependencies

package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd200;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_BODY = 5'b00010,
    PH_DIG1 = 5'b00100,
    PH_DIG2 = 5'b01000,
    PH_TAIL = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_DIGITS   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] body_length;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  // ascii hex digit decode, upper and lower case
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.bad   = 1'b0;
    d.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d.value = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

[design/nsc_parser.sv]
// sentence parser: phase tracking, running xor, digit capture and verdict
// depends on nsc_pkg

module nsc_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           max_length,
  output logic                 res_valid,
  output nsc_pkg::result_t     res
);

  nsc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [7:0] count_r, count_nxt;
  logic       derr_r, derr_nxt;
  logic [7:0] blen_r, blen_nxt;

  logic [8:0]          pos;
  nsc_pkg::hex_digit_t hd;

  assign pos = {1'b0, count_r} + 9'd1;
  assign hd  = nsc_pkg::hex_decode(rx_byte);

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    digit_nxt = digit_r;
    count_nxt = count_r;
    derr_nxt  = derr_r;
    blen_nxt  = blen_r;
    res_valid = 1'b0;
    res.status            = nsc_pkg::ST_GOOD;
    res.computed_checksum = xor_r;
    res.received_checksum = 8'd0;
    res.body_length       = blen_r;

    if (accept) begin
      if (phase_r == nsc_pkg::PH_HUNT) begin
        if (rx_byte == nsc_pkg::CH_DOLLAR) begin
          phase_nxt = nsc_pkg::PH_BODY;
          xor_nxt   = 8'd0;
          digit_nxt = 8'd0;
          derr_nxt  = 1'b0;
          blen_nxt  = 8'd0;
          count_nxt = 8'd1;
        end
      end else if (rx_byte == nsc_pkg::CH_LF) begin
        res_valid = 1'b1;
        phase_nxt = nsc_pkg::PH_HUNT;
        if (phase_r != nsc_pkg::PH_TAIL || derr_r) begin
          res.status = nsc_pkg::ST_DIGITS;
        end else begin
          res.received_checksum = digit_r;
          res.status = (digit_r == xor_r) ? nsc_pkg::ST_GOOD : nsc_pkg::ST_MISMATCH;
        end
      end else if (pos >= {1'b0, max_length}) begin
        res_valid  = 1'b1;
        res.status = nsc_pkg::ST_OVERFLOW;
        phase_nxt  = nsc_pkg::PH_HUNT;
      end else begin
        count_nxt = pos[7:0];
        case (phase_r)
          nsc_pkg::PH_BODY: begin
            if (rx_byte == nsc_pkg::CH_STAR) begin
              phase_nxt = nsc_pkg::PH_DIG1;
            end else begin
              xor_nxt  = xor_r ^ rx_byte;
              blen_nxt = blen_r + 8'd1;
            end
          end
          nsc_pkg::PH_DIG1: begin
            if (hd.bad) begin
              derr_nxt = 1'b1;
            end else begin
              digit_nxt = {hd.value, 4'd0};
            end
            phase_nxt = nsc_pkg::PH_DIG2;
          end
          nsc_pkg::PH_DIG2: begin
            if (hd.bad) begin
              derr_nxt = 1'b1;
            end else begin
              digit_nxt = {digit_r[7:4], hd.value};
            end
            phase_nxt = nsc_pkg::PH_TAIL;
          end
          default: begin
            phase_nxt = nsc_pkg::PH_TAIL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nsc_pkg::PH_HUNT;
      xor_r   <= 8'd0;
      digit_r <= 8'd0;
      count_r <= 8'd0;
      derr_r  <= 1'b0;
      blen_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      digit_r <= digit_nxt;
      count_r <= count_nxt;
      derr_r  <= derr_nxt;
      blen_r  <= blen_nxt;
    end
  end

endmodule

[design/nsc_out_buf.sv]
// two-entry result buffer: output register plus skid entry
// depends on nsc_pkg

module nsc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nsc_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output nsc_pkg::result_t  head
);

  logic [1:0]       count_r, count_nxt;
  nsc_pkg::result_t head_r, head_nxt;
  nsc_pkg::result_t skid_r, skid_nxt;
  logic             pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = count_r[1];
  assign head      = head_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    if (pop) begin
      if (count_r[1]) begin
        head_nxt  = skid_r;
        count_nxt = 2'd1;
      end else if (push) begin
        head_nxt  = push_data;
      end else begin
        count_nxt = 2'd0;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_nxt  = push_data;
        count_nxt = 2'd1;
      end else begin
        skid_nxt  = push_data;
        count_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[design/nmea_sentence_checksum_checker_top.sv]
// top level of the nmea 0183 sentence checksum checker
// depends on nsc_pkg, nsc_parser and nsc_out_buf

// Accepts one received character per clock cycle unless stalled and gives at
// most one verdict per sentence, buffered when the line feed (or the
// overflowing byte) is taken. The parser hunts for '$', xors every body byte
// up to '*', reads two hex digits (either case), ignores the tail and reports
// at line feed: good, mismatch, bad or missing digits, or overflow when
// max_length is reached. The rate is one byte per cycle unless stalled; a
// two-entry result buffer lets input keep flowing while a verdict waits, and
// in_stall rises only when both entries hold unread verdicts. The max_length
// register resets to 200 and is written through cfg_valid/cfg_ready, which is
// always ready; write it only while no sentence is in progress.

module nmea_sentence_checksum_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  // input request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result request channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_computed_checksum,
  output logic [7:0] out_received_checksum,
  output logic [7:0] out_body_length,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]       max_length_r;
  logic             accept;
  logic             res_valid;
  logic             buf_full;
  nsc_pkg::result_t res;
  nsc_pkg::result_t head;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= nsc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  // stall only when both result entries are occupied
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  nsc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .max_length (max_length_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  nsc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // unpack the head entry onto the result ports
  assign out_status            = head.status;
  assign out_computed_checksum = head.computed_checksum;
  assign out_received_checksum = head.received_checksum;
  assign out_body_length       = head.body_length;

endmodule

[sim/nmea_sentence_checksum_checker_top_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for nmea_sentence_checksum_checker_top: sentence traffic in,
// verdicts checked field by field against a cycle-free predictor in a small scoreboard class
// depends on nsc_pkg and the design sources

module nmea_sentence_checksum_checker_top_tb;

  // cycles with no handshake at all before the run is declared hung
  localparam int IDLE_LIMIT    = 2000;
  // the verdict is registered when the deciding byte is taken; spare cycles before cfg writes
  localparam int SETTLE_CYCLES = 8;
  // sentence bytes per max_length setting
  localparam int PHASE_ITEMS   = 150;
  // receiver hold-off length in cycles, spacing in verdicts
  localparam int HOLD_CYCLES   = 80;
  localparam int HOLD_EVERY    = 90;

  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {
    SENT_GOOD, SENT_MISMATCH, SENT_BAD_DIGIT, SENT_SHORT, SENT_OVERFLOW, SENT_GARBAGE
  } sentence_kind_t;

  // predicts one verdict per finished sentence and holds them until the block reports
  class sentence_verdict_board;
    nsc_pkg::phase_t  ph;
    logic [7:0]       xor_sum;
    logic [7:0]       digit_val;
    logic [7:0]       span;
    logic [7:0]       body_len;
    logic [7:0]       max_len;
    logic             bad_digit;
    nsc_pkg::result_t expected_verdicts[$];
    int               failures;
    int               verdicts_checked;

    function new();
      ph               = nsc_pkg::PH_HUNT;
      xor_sum          = '0;
      digit_val        = '0;
      span             = '0;
      body_len         = '0;
      bad_digit        = 1'b0;
      max_len          = nsc_pkg::MAX_LENGTH_RESET;
      failures         = 0;
      verdicts_checked = 0;
    endfunction

    function void set_max_length(input logic [7:0] v);
      max_len = v;
    endfunction

    function bit hunting();
      return ph == nsc_pkg::PH_HUNT;
    endfunction

    function int outstanding();
      return expected_verdicts.size();
    endfunction

    // 0..15 for a hex digit of either case, -1 otherwise
    function int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    // one accepted byte; pushes a verdict when it closes a sentence
    function void take_byte(input logic [7:0] c);
      logic [8:0]       pos;
      int               nib;
      nsc_pkg::result_t v;
      if (ph == nsc_pkg::PH_HUNT) begin
        if (c == nsc_pkg::CH_DOLLAR) begin
          ph        = nsc_pkg::PH_BODY;
          xor_sum   = '0;
          digit_val = '0;
          bad_digit = 1'b0;
          body_len  = '0;
          span      = 8'd1;
        end
        return;
      end
      pos                 = {1'b0, span} + 9'd1;
      v.computed_checksum = xor_sum;
      v.body_length       = body_len;
      v.received_checksum = '0;
      if (c == nsc_pkg::CH_LF) begin
        if (ph != nsc_pkg::PH_TAIL || bad_digit) begin
          v.status = nsc_pkg::ST_DIGITS;
        end else begin
          v.status            = (digit_val == xor_sum) ? nsc_pkg::ST_GOOD
                                                       : nsc_pkg::ST_MISMATCH;
          v.received_checksum = digit_val;
        end
      end else if (pos >= {1'b0, max_len}) begin
        v.status = nsc_pkg::ST_OVERFLOW;
      end else begin
        span = pos[7:0];
        case (ph)
          nsc_pkg::PH_BODY: begin
            if (c == nsc_pkg::CH_STAR) begin
              ph = nsc_pkg::PH_DIG1;
            end else begin
              xor_sum  = xor_sum ^ c;
              body_len = body_len + 8'd1;
            end
          end
          nsc_pkg::PH_DIG1: begin
            nib = nibble_of(c);
            if (nib < 0) bad_digit = 1'b1;
            else digit_val = {nib[3:0], 4'h0};
            ph = nsc_pkg::PH_DIG2;
          end
          nsc_pkg::PH_DIG2: begin
            nib = nibble_of(c);
            if (nib < 0) bad_digit = 1'b1;
            else digit_val = digit_val | {4'h0, nib[3:0]};
            ph = nsc_pkg::PH_TAIL;
          end
          default: ph = nsc_pkg::PH_TAIL;
        endcase
        return;
      end
      expected_verdicts.push_back(v);
      ph = nsc_pkg::PH_HUNT;
    endfunction

    task report(input string msg);
      if (failures < 50) $display("[%0t] verdict error: %s", $time, msg);
      failures++;
    endtask

    task check_verdict(input nsc_pkg::result_t got);
      nsc_pkg::result_t want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("verdict with nothing pending, status %0d", got.status));
        return;
      end
      want = expected_verdicts.pop_front();
      verdicts_checked++;
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.computed_checksum !== want.computed_checksum)
        report($sformatf("computed_checksum %02h, expected %02h",
                         got.computed_checksum, want.computed_checksum));
      if (got.received_checksum !== want.received_checksum)
        report($sformatf("received_checksum %02h, expected %02h",
                         got.received_checksum, want.received_checksum));
      if (got.body_length !== want.body_length)
        report($sformatf("body_length %0d, expected %0d",
                         got.body_length, want.body_length));
    endtask
  endclass

  logic       clk                   = 1'b0;
  logic       rst_n                 = 1'b0;
  logic       in_valid              = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte            = 8'h00;
  logic       out_valid;
  logic       out_stall             = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_computed_checksum;
  logic [7:0] out_received_checksum;
  logic [7:0] out_body_length;
  logic       cfg_valid             = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data              = 8'h00;

  sentence_verdict_board board;

  logic [7:0]  tx_bytes[$];          // bytes waiting to be offered
  logic [7:0]  cur_max_length = nsc_pkg::MAX_LENGTH_RESET;
  int          payload_items  = 0;   // sentence bytes offered (hunt noise excluded)
  int          settings_done  = 0;
  int          burst_left     = 0;
  int          idle_cycles    = 0;
  int          hold_left      = 0;
  int          next_hold_at   = 20;
  int          mode_left      = 0;
  stall_mode_t stall_mode     = STALL_NONE;

  nmea_sentence_checksum_checker_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_computed_checksum (out_computed_checksum),
    .out_received_checksum (out_received_checksum),
    .out_body_length       (out_body_length),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_data              (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // byte source: bursts of random length separated by random gaps; the payload
  // is only replaced after the edge that accepted it, so a stalled request holds
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // a third of the bursts follow straight on, giving long unbroken stretches
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    // in_stall still shows its pre-edge value here, i.e. the one that edge saw
    while (in_stall) @(posedge clk);
    board.take_byte(b);
  endtask

  task automatic flush_tx(input bit counted);
    while (tx_bytes.size() > 0) begin
      if (counted) payload_items++;
      send_byte(tx_bytes.pop_front());
    end
  endtask

  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // max_length only changes between sentences with no verdict in flight
  task automatic write_max_length(input logic [7:0] v);
    // a sentence left open by garbage bytes is closed with a line feed
    if (!board.hunting()) send_byte(nsc_pkg::CH_LF);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_max_length(v);
    cur_max_length = v;
    settings_done++;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  // hex digit character, letters in random case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] non_lf_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == nsc_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = non_lf_char(); while (board.nibble_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = non_lf_char(); while (c == nsc_pkg::CH_STAR);
    return c;
  endfunction

  // bytes dropped while hunting; never a dollar so they cannot open a sentence
  function automatic void queue_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 4)) begin
      do c = 8'($urandom_range(0, 255)); while (c == nsc_pkg::CH_DOLLAR);
      tx_bytes.push_back(c);
    end
  endfunction

  // one sentence, mostly well formed, sized for the current max_length
  function automatic void queue_sentence();
    int             ml;
    int             body_n;
    int             roll;
    int             kept;
    sentence_kind_t kind;
    logic [7:0]     b;
    logic [7:0]     sum;
    logic [7:0]     val;
    logic [7:0]     d1;
    logic [7:0]     d2;
    ml   = int'(cur_max_length);
    roll = $urandom_range(0, 99);
    kind = roll < 55 ? SENT_GOOD      :
           roll < 70 ? SENT_MISMATCH  :
           roll < 78 ? SENT_BAD_DIGIT :
           roll < 85 ? SENT_SHORT     :
           roll < 92 ? SENT_OVERFLOW  : SENT_GARBAGE;
    tx_bytes.push_back(nsc_pkg::CH_DOLLAR);
    if (kind == SENT_OVERFLOW) begin
      // last of these lands exactly on the length limit
      repeat (ml - 1) tx_bytes.push_back(non_lf_char());
      return;
    end
    if (kind == SENT_GARBAGE) begin
      repeat ($urandom_range(1, 10)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      tx_bytes.push_back(nsc_pkg::CH_LF);
      return;
    end
    // now and then a body that just fits, or overflows on the second digit
    if ($urandom_range(0, 11) == 0) body_n = ml - 5 + $urandom_range(0, 1);
    else body_n = $urandom_range(0, (ml - 5 < 12) ? ml - 5 : 12);
    sum = '0;
    repeat (body_n) begin
      b   = body_char();
      sum = sum ^ b;
      tx_bytes.push_back(b);
    end
    val = (kind == SENT_MISMATCH) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    d1  = hex_char(val[7:4]);
    d2  = hex_char(val[3:0]);
    if (kind == SENT_BAD_DIGIT) begin
      if ($urandom_range(0, 1) == 0) d1 = non_hex_char();
      else d2 = non_hex_char();
    end
    // short sentences stop before the star, after it, or after one digit
    kept = (kind == SENT_SHORT) ? $urandom_range(0, 2) : 3;
    if (kept > 0) tx_bytes.push_back(nsc_pkg::CH_STAR);
    if (kept > 1) tx_bytes.push_back(d1);
    if (kept > 2) tx_bytes.push_back(d2);
    if (kept == 3 && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2))
        tx_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_CR : non_lf_char());
    end
    tx_bytes.push_back(nsc_pkg::CH_LF);
  endfunction

  task automatic run_phase(input int budget);
    int start;
    start = payload_items;
    while (payload_items - start < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_noise();
        flush_tx(1'b0);
      end
      queue_sentence();
      flush_tx(1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // verdict sink: checks on the pre-edge handshake, then picks the next stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : verdict_sink
    nsc_pkg::result_t got;
    if (out_valid && !out_stall) begin
      got.status            = nsc_pkg::status_t'(out_status);
      got.computed_checksum = out_computed_checksum;
      got.received_checksum = out_received_checksum;
      got.body_length       = out_body_length;
      board.check_verdict(got);
    end
    // long hold-off every so many verdicts: the two-entry buffer fills and
    // in_stall has to rise while the source keeps offering bytes
    if (hold_left == 0 && board.verdicts_checked >= next_hold_at) begin
      hold_left    = HOLD_CYCLES;
      next_hold_at = next_hold_at + HOLD_EVERY;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(8, 64);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
        default:     out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // hang detector: any accepted request on any channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d verdicts pending",
               IDLE_LIMIT, board.outstanding());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int lengths[$];
    board   = new();
    // extremes 8 and 255 twice each; between them every cfg bit sees both values
    lengths = '{8, 255, 21, 100, 0, 13, 255, 0, 9, 8};
    lengths[4] = $urandom_range(8, 255);
    lengths[7] = $urandom_range(8, 255);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed sentences at the reset length of 200
    tx_bytes.push_back(8'h00);                 // dropped while hunting
    flush_tx(1'b0);
    tx_bytes.push_back(nsc_pkg::CH_DOLLAR);    // top body byte, mixed-case digits, cr tail
    tx_bytes.push_back(8'hFF);
    push_text("*fF\r\n");
    push_text("$$*25\n");                      // dollar inside the body, wrong checksum
    push_text("$\n");                          // line feed before the star
    push_text("$*1\n");                        // line feed after one digit
    push_text("$*0g\n");                       // non-hex digit
    flush_tx(1'b1);

    foreach (lengths[i]) begin
      write_max_length(8'(lengths[i]));
      run_phase(PHASE_ITEMS);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d sentence bytes over %0d max_length settings (8 to 255)",
             payload_items, settings_done);
    $display("checked %0d verdicts, %0d field errors", board.verdicts_checked,
             board.failures);
    if (board.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
design/nsc_pkg.sv
design/nsc_parser.sv
design/nsc_out_buf.sv
design/nmea_sentence_checksum_checker_top.sv
sim/nmea_sentence_checksum_checker_top_tb.sv
